### rtl/core/rot_pkg.sv
// Shared types and constants for the resource ownership table.
// Operation codes, sequencer states and memory word layouts.
// No dependencies.
package rot_pkg;

    localparam int RES_W  = 32;
    localparam int OWN_W  = 8;
    localparam int FUNC_W = 2;

    // Operation codes carried in the func field
    localparam logic [FUNC_W-1:0] FUNC_CLAIM   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FORBID  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BAN_SCAN,
        ST_OWN_SCAN,
        ST_REL_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] resource;
        logic [OWN_W-1:0] owner;
    } own_word_t;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] resource;
    } ban_word_t;

    localparam int OWN_WORD_W = $bits(own_word_t);
    localparam int BAN_WORD_W = $bits(ban_word_t);

endpackage

### rtl/core/rot_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the ownership table and the forbidden set. No dependencies.
module rot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rot_ctrl.sv
// Sequencer of the resource ownership table: clearing pass, forbidden-set and
// ownership scans, read-modify-write of the two memories, result register.
// Depends on rot_pkg; the memories sit outside in rot_ram instances.
module rot_ctrl #(
    parameter int OWNER_ENTRIES  = 64,
    parameter int BANNED_ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rot_pkg::RES_W-1:0]       cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rot_pkg::FUNC_W-1:0]      func,
    input  logic [rot_pkg::RES_W-1:0]       resource_id,
    input  logic [rot_pkg::OWN_W-1:0]       requester,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            granted,
    output logic                            status,
    output logic                            own_we,
    output logic [$clog2(OWNER_ENTRIES)-1:0] own_waddr,
    output rot_pkg::own_word_t              own_wdata,
    output logic [$clog2(OWNER_ENTRIES)-1:0] own_raddr,
    input  rot_pkg::own_word_t              own_rdata,
    output logic                            ban_we,
    output logic [((BANNED_ENTRIES > 1) ? $clog2(BANNED_ENTRIES) : 1)-1:0] ban_waddr,
    output rot_pkg::ban_word_t              ban_wdata,
    output logic [((BANNED_ENTRIES > 1) ? $clog2(BANNED_ENTRIES) : 1)-1:0] ban_raddr,
    input  rot_pkg::ban_word_t              ban_rdata
);

    import rot_pkg::*;

    localparam int OWN_AW = $clog2(OWNER_ENTRIES);
    localparam int BAN_AW = (BANNED_ENTRIES > 1) ? $clog2(BANNED_ENTRIES) : 1;
    localparam int MAX_N  = (OWNER_ENTRIES > BANNED_ENTRIES) ? OWNER_ENTRIES : BANNED_ENTRIES;
    localparam int CNT_W  = $clog2(MAX_N + 1);

    localparam logic [CNT_W-1:0] OWN_N    = CNT_W'(OWNER_ENTRIES);
    localparam logic [CNT_W-1:0] BAN_N    = CNT_W'(BANNED_ENTRIES);
    localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(MAX_N - 1);

    state_t             state_reg, state_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [RES_W-1:0]   id_reg, id_next;
    logic [OWN_W-1:0]   who_reg, who_next;
    logic [RES_W-1:0]   root_reg;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic [CNT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]   free_idx_reg, free_idx_next;
    logic               free_found_reg, free_found_next;
    logic               res_granted_reg, res_granted_next;
    logic               res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic               granted_reg, granted_next;
    logic               status_reg, status_next;

    logic               accept;
    logic               out_free;
    logic [CNT_W-1:0]   scan_n;
    logic               rd_ok;
    logic               last_cmp;
    logic               ban_hit, ban_free;
    logic               own_hit, own_free, rel_hit;
    logic [CNT_W-1:0]   slot_idx;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;
    assign status    = status_reg;

    // Scan bookkeeping: a read issued at iss_reg is compared in the next cycle
    assign scan_n   = (state_reg == ST_BAN_SCAN) ? BAN_N : OWN_N;
    assign rd_ok    = (iss_reg < scan_n);
    assign last_cmp = cmp_valid_reg && (cmp_idx_reg == scan_n - CNT_W'(1));
    assign ban_hit  = cmp_valid_reg && ban_rdata.valid && (ban_rdata.resource == id_reg);
    assign ban_free = cmp_valid_reg && !ban_rdata.valid;
    assign own_hit  = cmp_valid_reg && own_rdata.valid && (own_rdata.resource == id_reg);
    assign own_free = cmp_valid_reg && !own_rdata.valid;
    assign rel_hit  = cmp_valid_reg && own_rdata.valid && (own_rdata.owner == who_reg);
    assign slot_idx = free_found_reg ? free_idx_reg : cmp_idx_reg;

    assign own_raddr = iss_reg[OWN_AW-1:0];
    assign ban_raddr = iss_reg[BAN_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (iss_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (func == FUNC_CLAIM && resource_id == root_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (func == FUNC_CLAIM || func == FUNC_FORBID)
                    begin
                        state_next = ST_BAN_SCAN;
                    end
                    else if (func == FUNC_RELEASE)
                    begin
                        state_next = ST_REL_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_BAN_SCAN:
            begin
                if (ban_hit)
                begin
                    state_next = ST_DONE;
                end
                else if (last_cmp)
                begin
                    state_next = (func_reg == FUNC_CLAIM) ? ST_OWN_SCAN : ST_DONE;
                end
            end
            ST_OWN_SCAN:
            begin
                if (own_hit || last_cmp)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_REL_SCAN:
            begin
                if (last_cmp)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        func_next        = func_reg;
        id_next          = id_reg;
        who_next         = who_reg;
        iss_next         = iss_reg;
        cmp_idx_next     = iss_reg;
        cmp_valid_next   = 1'b0;
        free_idx_next    = free_idx_reg;
        free_found_next  = free_found_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        granted_next     = granted_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        own_we           = 1'b0;
        own_waddr        = cmp_idx_reg[OWN_AW-1:0];
        own_wdata        = '0;
        ban_we           = 1'b0;
        ban_waddr        = slot_idx[BAN_AW-1:0];
        ban_wdata        = '0;

        if (state_reg == ST_BAN_SCAN || state_reg == ST_OWN_SCAN || state_reg == ST_REL_SCAN)
        begin
            cmp_valid_next = rd_ok;
            if (rd_ok)
            begin
                iss_next = iss_reg + CNT_W'(1);
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep both memories, invalidating every entry
                iss_next  = iss_reg + CNT_W'(1);
                own_we    = (iss_reg < OWN_N);
                own_waddr = iss_reg[OWN_AW-1:0];
                ban_we    = (iss_reg < BAN_N);
                ban_waddr = iss_reg[BAN_AW-1:0];
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next        = func;
                    id_next          = resource_id;
                    who_next         = requester;
                    iss_next         = '0;
                    free_found_next  = 1'b0;
                    res_granted_next = 1'b0;
                    res_status_next  = 1'b0;
                end
            end
            ST_BAN_SCAN:
            begin
                if (!free_found_reg && ban_free)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (!ban_hit && last_cmp)
                begin
                    if (func_reg == FUNC_CLAIM)
                    begin
                        // Restart the scan over the ownership table
                        iss_next        = '0;
                        cmp_valid_next  = 1'b0;
                        free_found_next = 1'b0;
                    end
                    else if (free_found_reg || ban_free)
                    begin
                        ban_we             = 1'b1;
                        ban_wdata.valid    = 1'b1;
                        ban_wdata.resource = id_reg;
                    end
                    else
                    begin
                        res_status_next = 1'b1;
                    end
                end
            end
            ST_OWN_SCAN:
            begin
                if (!free_found_reg && own_free)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (own_hit)
                begin
                    res_granted_next = (own_rdata.owner == who_reg);
                end
                else if (last_cmp)
                begin
                    if (free_found_reg || own_free)
                    begin
                        own_we             = 1'b1;
                        own_waddr          = slot_idx[OWN_AW-1:0];
                        own_wdata.valid    = 1'b1;
                        own_wdata.resource = id_reg;
                        own_wdata.owner    = who_reg;
                        res_granted_next   = 1'b1;
                    end
                    else
                    begin
                        res_status_next = 1'b1;
                    end
                end
            end
            ST_REL_SCAN:
            begin
                // Drop the entry just compared; reads run ahead of this address
                if (rel_hit)
                begin
                    own_we             = 1'b1;
                    own_wdata.valid    = 1'b0;
                    own_wdata.resource = own_rdata.resource;
                    own_wdata.owner    = own_rdata.owner;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = res_granted_reg;
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
                iss_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            root_reg       <= '0;
            iss_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            cmp_valid_reg  <= cmp_valid_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                root_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        id_reg          <= id_next;
        who_reg         <= who_next;
        cmp_idx_reg     <= cmp_idx_next;
        free_idx_reg    <= free_idx_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        granted_reg     <= granted_next;
        status_reg      <= status_next;
    end

    // A new ownership entry ends the claim, so no second write follows it
    a_single_store: assert property (@(posedge clk) disable iff (!rst_n)
        (own_we && own_wdata.valid) |=> !own_we)
        else $error("ownership table written twice by one claim");

    // Memories change only during the clearing pass or a scan
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        (own_we || ban_we) |-> (state_reg == ST_CLEAR || state_reg == ST_BAN_SCAN ||
                                state_reg == ST_OWN_SCAN || state_reg == ST_REL_SCAN))
        else $error("memory write outside a scan");

    // Only a claim can report a grant
    a_grant_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free && res_granted_reg) |-> (func_reg == FUNC_CLAIM))
        else $error("grant reported for an operation other than a claim");

    // A result word appears only out of the result state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the result state");

endmodule

### rtl/core/resource_ownership_table.sv
// Top level of the resource ownership table: configuration register port,
// sequencer and the two table memories. Depends on rot_pkg, rot_ctrl, rot_ram.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   func, resource_id, requester
//   out      output     out_valid / out_stall granted, status
//   cfg      input      cfg_wr_en             cfg_wr_data (root resource id)
//
// One operation at a time; the next word is taken while a result waits in the
// output register. A claim of any id but the root scans the forbidden set, then
// the ownership table; a forbid scans the forbidden set, a release the ownership
// table, each scan reading one entry per cycle through the read port of its memory.
// After reset a clearing pass invalidates every entry of both memories; in_stall
// stays high meanwhile.
// out_stall holds the result register; the next operation runs until done and waits.
module resource_ownership_table #(
    parameter int OWNER_ENTRIES  = 64,
    parameter int BANNED_ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rot_pkg::RES_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [rot_pkg::FUNC_W-1:0] func,
    input  logic [rot_pkg::RES_W-1:0]  resource_id,
    input  logic [rot_pkg::OWN_W-1:0]  requester,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       granted,
    output logic                       status
);

    import rot_pkg::*;

    localparam int OWN_AW = $clog2(OWNER_ENTRIES);
    localparam int BAN_AW = (BANNED_ENTRIES > 1) ? $clog2(BANNED_ENTRIES) : 1;

    logic              own_we;
    logic [OWN_AW-1:0] own_waddr, own_raddr;
    own_word_t         own_wdata, own_rdata;
    logic              ban_we;
    logic [BAN_AW-1:0] ban_waddr, ban_raddr;
    ban_word_t         ban_wdata, ban_rdata;

    rot_ctrl #(
        .OWNER_ENTRIES  (OWNER_ENTRIES),
        .BANNED_ENTRIES (BANNED_ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .resource_id (resource_id),
        .requester   (requester),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .granted     (granted),
        .status      (status),
        .own_we      (own_we),
        .own_waddr   (own_waddr),
        .own_wdata   (own_wdata),
        .own_raddr   (own_raddr),
        .own_rdata   (own_rdata),
        .ban_we      (ban_we),
        .ban_waddr   (ban_waddr),
        .ban_wdata   (ban_wdata),
        .ban_raddr   (ban_raddr),
        .ban_rdata   (ban_rdata)
    );

    rot_ram #(
        .WIDTH (OWN_WORD_W),
        .DEPTH (OWNER_ENTRIES)
    ) u_own_ram (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    rot_ram #(
        .WIDTH (BAN_WORD_W),
        .DEPTH (BANNED_ENTRIES)
    ) u_ban_ram (
        .clk   (clk),
        .we    (ban_we),
        .waddr (ban_waddr),
        .wdata (ban_wdata),
        .raddr (ban_raddr),
        .rdata (ban_rdata)
    );

endmodule
